@@ hdl/mts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg: shared types and codes for the min tracking stack
// Transaction payloads, command and status codes, cell shift controls.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic signed [31:0] current_min;
        logic [1:0]         status;
        logic [7:0]         entry_count;
    } rsp_t;

    typedef struct packed {
        logic val_push;
        logic val_pop;
        logic min_push;
        logic min_pop;
    } shift_t;

endpackage

@@ hdl/mts_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_cell: one stack slot
// Holds one value entry and one running-minimum entry; shifts each toward
// the bottom on push and toward the top on pop.
// ----------------------------------------------------------------------------
module mts_cell (
    input  logic                clk,
    input  mts_pkg::shift_t     ctrl,
    input  logic signed [31:0]  above_val,
    input  logic signed [31:0]  below_val,
    input  logic signed [31:0]  above_min,
    input  logic signed [31:0]  below_min,
    output logic signed [31:0]  val_reg,
    output logic signed [31:0]  min_reg
);

    logic signed [31:0] val_next;
    logic signed [31:0] min_next;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.val_push)
        begin
            val_next = above_val;
        end
        else if (ctrl.val_pop)
        begin
            val_next = below_val;
        end
        min_next = min_reg;
        if (ctrl.min_push)
        begin
            min_next = above_min;
        end
        else if (ctrl.min_pop)
        begin
            min_next = below_min;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        min_reg <= min_next;
    end

endmodule

@@ hdl/min_tracking_stack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_tracking_stack: LIFO stack of signed values with running minimum
// A row of cells shifts values and minima; the top cell is the stack top.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: drive request (command, value) and raise start; the
//   transaction is taken at the rising edge where start is high and busy
//   is low. busy stays low, so one transaction may be issued every cycle.
//   Commands: push, pop, or read of minimum and status.
//   Response channel: result is valid for one cycle while done is high,
//   in the cycle after the request edge (throughput 1 per cycle).
//   Both tops sit in the first cell, so each command finishes in the cycle
//   it is taken; a push or pop shifts the value row one slot in that same edge.
//   The receiver cannot stall; each result must be taken when done is high.
//   Reset clears the entry counts and the response strobe; the cell
//   contents stay undefined until pushed.
// ----------------------------------------------------------------------------
module min_tracking_stack #(
    parameter int STACK_DEPTH = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  mts_pkg::req_t  request,
    output logic           done,
    output mts_pkg::rsp_t  result
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic signed [31:0] val_q [STACK_DEPTH];
    logic signed [31:0] min_q [STACK_DEPTH];

    logic [CW-1:0]      val_count_reg, val_count_next;
    logic [CW-1:0]      min_count_reg, min_count_next;
    logic               done_reg, done_next;
    mts_pkg::rsp_t      result_reg, result_next;
    mts_pkg::shift_t    shift;
    logic               accept;
    logic               is_full;
    logic               is_empty;
    logic signed [31:0] min_top_next;
    logic [CW+7:0]      count_ext;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign is_full  = (val_count_reg == CW'(STACK_DEPTH));
    assign is_empty = (val_count_reg == '0);

    always_comb
    begin
        shift          = '0;
        val_count_next = val_count_reg;
        min_count_next = min_count_reg;
        min_top_next   = min_q[0];
        result_next    = '0;
        result_next.status = mts_pkg::ST_OK;
        if (accept)
        begin
            case (request.command)
                mts_pkg::CMD_PUSH:
                begin
                    if (is_full)
                    begin
                        result_next.status = mts_pkg::ST_FULL;
                    end
                    else
                    begin
                        shift.val_push = 1'b1;
                        val_count_next = val_count_reg + 1'b1;
                        if ((min_count_reg == '0) ||
                            ((min_count_reg < CW'(STACK_DEPTH)) &&
                             (request.value <= min_q[0])))
                        begin
                            shift.min_push = 1'b1;
                            min_count_next = min_count_reg + 1'b1;
                            min_top_next   = request.value;
                        end
                    end
                end
                mts_pkg::CMD_POP:
                begin
                    if (is_empty)
                    begin
                        result_next.status = mts_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        shift.val_pop = 1'b1;
                        val_count_next = val_count_reg - 1'b1;
                        result_next.popped_value = val_q[0];
                        if ((min_count_reg != '0) && (val_q[0] == min_q[0]))
                        begin
                            shift.min_pop  = 1'b1;
                            min_count_next = min_count_reg - 1'b1;
                            min_top_next   = min_q[1];
                        end
                    end
                end
                default:
                begin
                    if (is_empty)
                    begin
                        result_next.status = mts_pkg::ST_EMPTY;
                    end
                end
            endcase
        end
        count_ext = {8'd0, val_count_next};
        result_next.entry_count = count_ext[7:0];
        if ((val_count_next == '0) || (min_count_next == '0))
        begin
            result_next.current_min = '0;
        end
        else
        begin
            result_next.current_min = min_top_next;
        end
        done_next = accept;
    end

    genvar i;
    generate
        for (i = 0; i < STACK_DEPTH; i++)
        begin : g_cell
            logic signed [31:0] above_val, above_min, below_val, below_min;
            if (i == 0)
            begin : g_top
                assign above_val = request.value;
                assign above_min = request.value;
            end
            else
            begin : g_mid
                assign above_val = val_q[i-1];
                assign above_min = min_q[i-1];
            end
            if (i == STACK_DEPTH - 1)
            begin : g_bot
                assign below_val = '0;
                assign below_min = '0;
            end
            else
            begin : g_up
                assign below_val = val_q[i+1];
                assign below_min = min_q[i+1];
            end
            mts_cell u_cell (
                .clk       (clk),
                .ctrl      (shift),
                .above_val (above_val),
                .below_val (below_val),
                .above_min (above_min),
                .below_min (below_min),
                .val_reg   (val_q[i]),
                .min_reg   (min_q[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_count_reg <= '0;
            min_count_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            val_count_reg <= val_count_next;
            min_count_reg <= min_count_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ hdl/mts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_checker: port-level checks for the min tracking stack
// Response timing and the payload of refused or empty transactions.
// ----------------------------------------------------------------------------
module mts_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input mts_pkg::req_t request,
    input logic          done,
    input mts_pkg::rsp_t result
);

    a_done_follows_request: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy)
    ) else $error("response without a request transaction");

    a_request_gets_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done
    ) else $error("request transaction without a response");

    a_empty_payload: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && (result.status == mts_pkg::ST_EMPTY)) |->
            ((result.popped_value == 0) && (result.current_min == 0) &&
             (result.entry_count == 0))
    ) else $error("empty status with nonzero payload");

    a_full_no_pop: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && (result.status == mts_pkg::ST_FULL)) |->
            ((result.popped_value == 0) &&
             ($past(request.command) == mts_pkg::CMD_PUSH))
    ) else $error("full status on a non-push transaction");

endmodule

bind min_tracking_stack mts_checker u_mts_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);
